>>> sv/ofwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the order-statistic Fenwick tree.
// No dependencies; compiled first.
package ofwt_pkg;

   // Field widths of the request and response beats
   localparam int MODE_W  = 2;
   localparam int POS_W   = 11;
   localparam int DELTA_W = 16;
   localparam int RANK_W  = 32;
   localparam int COUNT_W = 32;
   localparam int KTH_W   = 11;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KTH   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_COUNT,
      ST_KTH,
      ST_DONE
   } state_type;

endpackage

>>> sv/ofwt_ifs.sv
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready plus payload).
// Depends on ofwt_pkg for field widths.
interface ofwt_req_if;
   import ofwt_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [POS_W-1:0]   position;
   logic [DELTA_W-1:0] delta;
   logic [RANK_W-1:0]  rank;

   modport source (output valid, output mode, output position, output delta,
                   output rank, input ready);
   modport sink   (input valid, input mode, input position, input delta,
                   input rank, output ready);
endinterface

interface ofwt_rsp_if;
   import ofwt_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] prefix_count;
   logic [KTH_W-1:0]   kth_position;
   logic               found;

   modport source (output valid, output prefix_count, output kth_position,
                   output found, input ready);
   modport sink   (input valid, input prefix_count, input kth_position,
                   input found, output ready);
endinterface

>>> sv/ofwt_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.
module ofwt_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/order_statistic_fenwick_tree.sv
`timescale 1ns / 1ps
// Order-statistic Fenwick tree: node RAM plus walk sequencer.
// Depends on ofwt_pkg, ofwt_ifs (ofwt_req_if, ofwt_rsp_if) and ofwt_ram.
//
// Usage
//   req_if carries one operation per beat: add delta at position (mode 0),
//   prefix count up to position (mode 1), smallest position whose prefix
//   reaches rank (mode 2). Mode 3 is a no-op that still returns one beat.
//   rsp_if returns exactly one beat per request, in order. Fields that do
//   not belong to the operation read as zero.
//   Walks go node by node through the single read/write RAM pair:
//     add   : reads and rewrites each node of the upward walk, up to SIZE
//     count : one node per set bit of the (clamped) position
//     kth   : one probe per halving of the step, from the top power of two
//             <= SIZE down to one; a probe past SIZE makes no read
//   The response is then registered; only then is the next request taken.
//   Reset (synchronous): the block sweeps the node RAM to zero, one entry a
//   cycle, entries 0 to SIZE-1, with req_if.ready low throughout.
//   A stalled receiver is absorbed by the response register; the block
//   finishes the walk and then waits in DONE until that register frees up.
module order_statistic_fenwick_tree #(
   parameter int SIZE = 1024
) (
   input logic        clock,
   input logic        reset,
   ofwt_req_if.sink   req_if,
   ofwt_rsp_if.source rsp_if
);
   import ofwt_pkg::*;

   // AW addresses the RAM (node i lives at i-1); IW holds a node index with
   // room for the add walk overshooting SIZE.
   localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int IW = $clog2(SIZE + 1) + 1;
   localparam int PW = (IW > POS_W) ? IW : POS_W;

   localparam logic [IW-1:0] SIZE_N   = IW'(SIZE);
   localparam logic [IW-1:0] TOP_N    = IW'(1) << ($clog2(SIZE + 1) - 1);
   localparam logic [PW-1:0] SIZE_P   = PW'(SIZE);
   localparam logic [AW-1:0] CLR_LAST = AW'(SIZE - 1);

   state_type state_ff, state_in;

   logic [AW-1:0]      clr_ff, clr_in;
   logic [MODE_W-1:0]  op_ff, op_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [IW-1:0]      cur_ff, cur_in;      // node whose data is in the RAM register
   logic [IW-1:0]      step_ff, step_in;
   logic [IW-1:0]      base_ff, base_in;
   logic [RANK_W-1:0]  left_ff, left_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               pend_ff, pend_in;    // kth: RAM register holds node cur

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [KTH_W-1:0]   rsp_kth_ff;
   logic               rsp_found_ff;

   // RAM port signals
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [COUNT_W-1:0] wr_data, rd_data;
   logic [IW-1:0]      rd_node, rd_node_m1, cur_m1;

   logic               req_fire, rsp_free, rsp_load;

   // Start of a walk, taken straight from the request beat
   logic [PW-1:0]      pos_p;
   logic               add_ok;
   logic [IW-1:0]      cnt_start, start_node;
   logic               start_ok;

   // Next node of each walk
   logic [IW-1:0]      add_nxt, cnt_nxt, low_bit;
   logic               add_more, cnt_more;
   logic               take;
   logic [IW-1:0]      base_n, step_n, cand;
   logic [RANK_W-1:0]  left_n;
   logic               kth_more;
   logic [IW-1:0]      kth_val;

   ofwt_ram #(
      .DEPTH (SIZE),
      .WIDTH (COUNT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load = (state_ff == ST_DONE) && rsp_free;

   // Request decode: clamp count queries to SIZE, drop out-of-range adds
   assign pos_p     = PW'(req_if.position);
   assign add_ok    = (pos_p != '0) && (pos_p <= SIZE_P);
   assign cnt_start = (pos_p > SIZE_P) ? SIZE_N : IW'(pos_p);

   always_comb begin
      case (req_if.mode)
         MODE_ADD: begin
            start_node = IW'(pos_p);
            start_ok   = add_ok;
         end
         MODE_COUNT: begin
            start_node = cnt_start;
            start_ok   = (cnt_start != '0);
         end
         MODE_KTH: begin
            start_node = TOP_N;
            start_ok   = 1'b1;
         end
         default: begin
            start_node = '0;
            start_ok   = 1'b0;
         end
      endcase
   end

   // Upward walk (add) and downward walk (count)
   assign low_bit  = cur_ff & (~cur_ff + IW'(1));
   assign add_nxt  = cur_ff + low_bit;
   assign add_more = (add_nxt <= SIZE_N);
   assign cnt_nxt  = cur_ff & (cur_ff - IW'(1));
   assign cnt_more = (cnt_nxt != '0);

   // Top-down descent: one halving of step per cycle; a probe past SIZE
   // spends its cycle without a read.
   assign take     = pend_ff && (rd_data < left_ff);
   assign base_n   = take ? cur_ff : base_ff;
   assign left_n   = take ? (left_ff - rd_data) : left_ff;
   assign step_n   = step_ff >> 1;
   assign cand     = base_n + step_n;
   assign kth_more = (step_n != '0) && (cand <= SIZE_N);
   assign kth_val  = base_ff + IW'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.mode)
                  MODE_ADD:   state_in = add_ok ? ST_ADD : ST_DONE;
                  MODE_COUNT: state_in = (cnt_start != '0) ? ST_COUNT : ST_DONE;
                  MODE_KTH:   state_in = ST_KTH;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD: begin
            if (!add_more) begin
               state_in = ST_DONE;
            end
         end
         ST_COUNT: begin
            if (!cnt_more) begin
               state_in = ST_DONE;
            end
         end
         ST_KTH: begin
            if (step_n == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // RAM controls and handshake outputs
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_m1[AW-1:0];
      wr_data = rd_data + COUNT_W'(delta_ff);
      rd_en   = 1'b0;
      rd_node = start_node;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            rd_en   = req_fire && start_ok;
            rd_node = start_node;
         end
         ST_ADD: begin
            wr_en   = 1'b1;
            rd_en   = add_more;
            rd_node = add_nxt;
         end
         ST_COUNT: begin
            rd_en   = cnt_more;
            rd_node = cnt_nxt;
         end
         ST_KTH: begin
            rd_en   = kth_more;
            rd_node = cand;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign rd_node_m1 = rd_node - IW'(1);
   assign rd_addr    = rd_node_m1[AW-1:0];
   assign cur_m1     = cur_ff - IW'(1);

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.prefix_count = rsp_count_ff;
   assign rsp_if.kth_position = rsp_kth_ff;
   assign rsp_if.found        = rsp_found_ff;

   // Walk registers
   always_comb begin
      clr_in   = clr_ff;
      op_in    = op_ff;
      delta_in = delta_ff;
      cur_in   = cur_ff;
      step_in  = step_ff;
      base_in  = base_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_if.mode;
               delta_in = req_if.delta;
               cur_in   = start_node;
               step_in  = TOP_N;
               base_in  = '0;
               left_in  = req_if.rank;
               acc_in   = '0;
               pend_in  = 1'b1;
            end
         end
         ST_ADD: begin
            cur_in = add_nxt;
         end
         ST_COUNT: begin
            acc_in = acc_ff + rd_data;
            cur_in = cnt_nxt;
         end
         ST_KTH: begin
            base_in = base_n;
            left_in = left_n;
            step_in = step_n;
            cur_in  = cand;
            pend_in = kth_more;
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      delta_ff <= delta_in;
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      base_ff  <= base_in;
      left_ff  <= left_in;
      acc_ff   <= acc_in;
   end

   // Response register; fields outside the operation read as zero
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_count_ff <= (op_ff == MODE_COUNT) ? acc_ff : '0;
         rsp_kth_ff   <= (op_ff == MODE_KTH) ? KTH_W'(kth_val) : '0;
         rsp_found_ff <= (op_ff == MODE_KTH) && (kth_val <= SIZE_N);
      end
   end

endmodule

>>> dv/order_statistic_fenwick_tree_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the order-statistic Fenwick tree: directed and random
// add, count, kth and spare-mode beats against an in-bench tree model. Depends on
// ofwt_pkg, ofwt_ifs and order_statistic_fenwick_tree.
module order_statistic_fenwick_tree_tb;
   import ofwt_pkg::*;

   localparam int SIZE            = 1024;
   localparam int RANDOM_OPS      = 1050;
   localparam int WATCHDOG_CYCLES = 6000;  // longer than the clear sweep
   localparam int HOLD_AT_BEAT    = 400;   // response beat that starts the long hold
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_AT_OP     = 600;   // random op that waits for an empty pipe
   localparam int TAIL_CYCLES     = 40;

   // mode 3 has no package name; the block treats it as a no-op
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [POS_W-1:0]   position;
      logic [DELTA_W-1:0] delta;
      logic [RANK_W-1:0]  rank;
      logic               drain;   // hold off until every answer is back
   } fen_op_type;

   typedef struct packed {
      logic [COUNT_W-1:0] prefix_count;
      logic [KTH_W-1:0]   kth_position;
      logic               found;
   } fen_answer_type;

   logic clock;
   logic reset;

   ofwt_req_if req_bus ();
   ofwt_rsp_if rsp_bus ();

   order_statistic_fenwick_tree #(.SIZE(SIZE)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench-side tree: same node layout and walks as the block
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] fen_node [1:SIZE];

   function automatic int unsigned low_bit(int unsigned v);
      return v & (~v + 1);
   endfunction

   function automatic void fen_add(int unsigned pos, logic [COUNT_W-1:0] amount);
      int unsigned i;
      if (pos == 0 || pos > SIZE) return;   // out of range: tree untouched
      i = pos;
      while (i <= SIZE) begin
         fen_node[i] += amount;
         i += low_bit(i);
      end
   endfunction

   function automatic logic [COUNT_W-1:0] fen_prefix(int unsigned pos);
      logic [COUNT_W-1:0] total;
      int unsigned        i;
      total = '0;
      i = (pos > SIZE) ? SIZE : pos;        // past the end clamps to SIZE
      while (i >= 1) begin
         total += fen_node[i];
         i -= low_bit(i);
      end
      return total;
   endfunction

   // Top-down descent; yields SIZE+1 when the total is below the rank
   function automatic int unsigned fen_kth(logic [RANK_W-1:0] target);
      int unsigned        step;
      int unsigned        base;
      int unsigned        nxt;
      logic [COUNT_W-1:0] left;
      step = 1;
      base = 0;
      left = target;
      while ((step << 1) <= SIZE) step <<= 1;
      while (step != 0) begin
         nxt = base + step;
         if (nxt <= SIZE && fen_node[nxt] < left) begin
            base = nxt;
            left -= fen_node[nxt];
         end
         step >>= 1;
      end
      return base + 1;
   endfunction

   // Applies one op to the bench tree and returns the beat the block owes
   function automatic fen_answer_type fenwick_answer(fen_op_type op);
      fen_answer_type ans;
      int unsigned    k;
      ans = '0;
      case (op.mode)
         MODE_ADD: begin
            fen_add(op.position, {{(COUNT_W-DELTA_W){1'b0}}, op.delta});
         end
         MODE_COUNT: begin
            ans.prefix_count = fen_prefix(op.position);
         end
         MODE_KTH: begin
            k = fen_kth(op.rank);
            ans.kth_position = k[KTH_W-1:0];
            ans.found        = (k <= SIZE);
         end
         default: ;   // spare mode: all-zero beat
      endcase
      return ans;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation: flat shadow counts steer ranks onto real
   // prefix boundaries so the kth descent is exercised at its edges
   // ---------------------------------------------------------------------
   fen_op_type         pending_ops [$];
   fen_answer_type     expected_answers [$];
   logic [COUNT_W-1:0] shadow_cnt [1:SIZE];
   logic [COUNT_W-1:0] shadow_total;

   function automatic logic [COUNT_W-1:0] shadow_prefix(int unsigned pos);
      logic [COUNT_W-1:0] s;
      s = '0;
      for (int unsigned p = 1; p <= SIZE && p <= pos; p++) s += shadow_cnt[p];
      return s;
   endfunction

   function automatic void queue_op(logic [MODE_W-1:0] mode, int unsigned pos,
                                    int unsigned delta, logic [RANK_W-1:0] rank,
                                    logic drain);
      fen_op_type op;
      op.mode     = mode;
      op.position = pos[POS_W-1:0];
      op.delta    = delta[DELTA_W-1:0];
      op.rank     = rank;
      op.drain    = drain;
      if (mode == MODE_ADD && op.position >= 1 && op.position <= SIZE) begin
         shadow_cnt[op.position] += op.delta;
         shadow_total += op.delta;
      end
      pending_ops.push_back(op);
   endfunction

   function automatic int unsigned pick_pos();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(SIZE, 1);
      if (r < 92) return $urandom_range((1 << POS_W) - 1);   // 0 and past-the-end too
      case ($urandom_range(3))
         0: return 1;
         1: return SIZE;
         2: return SIZE - 1;
         default: return SIZE / 2;
      endcase
   endfunction

   function automatic int unsigned pick_delta();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return $urandom_range(3);       // many ties and empty slots
      if (r < 90) return $urandom_range(65535);
      return (r < 95) ? 65535 : 0;
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      int unsigned        r;
      int unsigned        p;
      logic [COUNT_W-1:0] edge_val;
      r = $urandom_range(99);
      if (r < 45) begin
         p = $urandom_range(SIZE, 1);
         edge_val = shadow_prefix(p);
         return edge_val + 32'($urandom_range(2)) - 32'd1;
      end
      if (r < 70) return $urandom_range(shadow_total + 1);
      if (r < 80) return shadow_total + 32'($urandom_range(1));
      if (r < 85) return '0;
      return $urandom();
   endfunction

   // Gap length for either side: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: request beats change on the falling edge
   // ---------------------------------------------------------------------
   logic        req_beat;    // request accepted at the last rising edge
   logic        rsp_beat;    // response accepted at the last rising edge
   int unsigned req_count;
   int unsigned rsp_count;
   int unsigned send_gap;

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (req_bus.valid && !req_beat) begin
         // beat still on offer: hold it steady
      end else if (send_gap != 0) begin
         send_gap      <= send_gap - 1;
         req_bus.valid <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_answers.size() != 0)) begin
         req_bus.valid    <= 1'b1;
         req_bus.mode     <= pending_ops[0].mode;
         req_bus.position <= pending_ops[0].position;
         req_bus.delta    <= pending_ops[0].delta;
         req_bus.rank     <= pending_ops[0].rank;
         // in every second run of 128 beats the sender runs back to back
         send_gap         <= req_count[7] ? 0 : pick_gap();
         void'(pending_ops.pop_front());
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready stalls after beats, plus one long hold that backs the
   // block up until it drops its own ready
   // ---------------------------------------------------------------------
   int unsigned recv_stall;
   int unsigned hold_left;
   logic        hold_done;

   always @(negedge clock) begin : recv_drive
      int unsigned g;
      g = pick_gap();
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall    <= 0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AT_BEAT) begin
         hold_done     <= 1'b1;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_stall != 0) begin
         recv_stall    <= recv_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_beat && g != 0 && rsp_count[7:6] != 2'b11) begin
         recv_stall    <= g - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on request beats, check on response beats
   // ---------------------------------------------------------------------
   int unsigned errors;

   always @(posedge clock) begin : beat_monitor
      fen_op_type     op;
      fen_answer_type want;
      req_beat <= !reset && req_bus.valid && req_bus.ready;
      rsp_beat <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         op.mode     = req_bus.mode;
         op.position = req_bus.position;
         op.delta    = req_bus.delta;
         op.rank     = req_bus.rank;
         op.drain    = 1'b0;
         expected_answers.push_back(fenwick_answer(op));
         req_count <= req_count + 1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response beat: prefix_count %0d kth_position %0d found %0d",
                     $realtime, rsp_bus.prefix_count, rsp_bus.kth_position, rsp_bus.found);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_bus.prefix_count !== want.prefix_count) begin
               $display("%0t: prefix_count mismatch: expected %0d actual %0d",
                        $realtime, want.prefix_count, rsp_bus.prefix_count);
               errors++;
            end
            if (rsp_bus.kth_position !== want.kth_position) begin
               $display("%0t: kth_position mismatch: expected %0d actual %0d",
                        $realtime, want.kth_position, rsp_bus.kth_position);
               errors++;
            end
            if (rsp_bus.found !== want.found) begin
               $display("%0t: found mismatch: expected %0d actual %0d",
                        $realtime, want.found, rsp_bus.found);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long with no beat on either channel ends the run
   int unsigned quiet_cycles;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: watchdog expired with %0d answers outstanding",
                  $realtime, expected_answers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, directed ops, random ops, drain, verdict
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      int unsigned r;
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.mode     = '0;
      req_bus.position = '0;
      req_bus.delta    = '0;
      req_bus.rank     = '0;
      rsp_bus.ready    = 1'b0;
      req_beat         = 1'b0;
      rsp_beat         = 1'b0;
      req_count        = 0;
      rsp_count        = 0;
      errors           = 0;
      quiet_cycles     = 0;
      shadow_total     = '0;
      for (int i = 1; i <= SIZE; i++) begin
         fen_node[i]   = '0;
         shadow_cnt[i] = '0;
      end

      // empty tree: rank zero hits position 1, rank one finds nothing
      queue_op(MODE_KTH,   0, 0, 32'd0, 1'b0);
      queue_op(MODE_KTH,   0, 0, 32'd1, 1'b0);
      queue_op(MODE_COUNT, SIZE, 0, 32'd0, 1'b0);
      // adds at both ends, plus ones outside the range that must be ignored
      queue_op(MODE_ADD,   1, 65535, 32'd0, 1'b0);
      queue_op(MODE_ADD,   SIZE, 1, 32'd0, 1'b0);
      queue_op(MODE_ADD,   0, 16'h1234, 32'd0, 1'b0);
      queue_op(MODE_ADD,   SIZE + 1, 7, 32'd0, 1'b0);
      queue_op(MODE_ADD,   (1 << POS_W) - 1, 65535, 32'hFFFF_FFFF, 1'b0);
      queue_op(MODE_ADD,   SIZE / 2, 0, 32'd0, 1'b0);
      queue_op(MODE_ADD,   700, 300, 32'd0, 1'b0);
      // prefix counts: zero position, 1, SIZE-1, and past the end
      queue_op(MODE_COUNT, 0, 0, 32'd0, 1'b0);
      queue_op(MODE_COUNT, 1, 0, 32'd0, 1'b0);
      queue_op(MODE_COUNT, SIZE - 1, 0, 32'd0, 1'b0);
      queue_op(MODE_COUNT, (1 << POS_W) - 1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      // kth across the first boundary, at the total and just past it
      queue_op(MODE_KTH,   0, 0, 32'd65535, 1'b0);
      queue_op(MODE_KTH,   0, 0, 32'd65536, 1'b0);
      queue_op(MODE_KTH,   0, 0, shadow_total, 1'b0);
      queue_op(MODE_KTH,   0, 0, shadow_total + 1, 1'b0);
      queue_op(MODE_KTH,   0, 0, shadow_total + 2, 1'b0);
      queue_op(MODE_KTH,   (1 << POS_W) - 1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      // spare mode, all ones then all zeros, then a count after a full drain
      queue_op(MODE_SPARE, (1 << POS_W) - 1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_op(MODE_SPARE, 0, 0, 32'd0, 1'b1);
      queue_op(MODE_COUNT, SIZE, 0, 32'd0, 1'b1);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         r = $urandom_range(99);
         if (r < 40)
            queue_op(MODE_ADD, pick_pos(), pick_delta(), $urandom(), n == DRAIN_AT_OP);
         else if (r < 65)
            queue_op(MODE_COUNT, pick_pos(), $urandom_range(65535), $urandom(),
                     n == DRAIN_AT_OP);
         else if (r < 95)
            queue_op(MODE_KTH, $urandom_range((1 << POS_W) - 1), $urandom_range(65535),
                     pick_rank(), n == DRAIN_AT_OP);
         else
            queue_op(MODE_SPARE, $urandom_range((1 << POS_W) - 1), $urandom_range(65535),
                     $urandom(), n == DRAIN_AT_OP);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_bus.valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_answers.size() != 0) begin
         $display("%0t: %0d answers never arrived", $realtime, expected_answers.size());
         errors++;
      end
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
sv/ofwt_pkg.sv
sv/ofwt_ifs.sv
sv/ofwt_ram.sv
sv/order_statistic_fenwick_tree.sv
dv/order_statistic_fenwick_tree_tb.sv
